[rtl/rrts_pkg.sv]
// shared types and constants for the round robin thread scheduler
// used by rrts_ctrl, rrts_dp and round_robin_thread_scheduler; no dependencies
`default_nettype none

package rrts_pkg;

  localparam int THREAD_COUNT = 6;
  localparam int SEMA_COUNT   = 4;

  // fixed field widths of the request and result
  localparam int THREAD_W = 3;
  localparam int SEMA_ID_W = 2;
  localparam int VAL_W = 16;

  localparam int THREAD_IDX_W = $clog2(THREAD_COUNT);
  localparam int SEMA_IDX_W   = (SEMA_COUNT > 1) ? $clog2(SEMA_COUNT) : 1;
  localparam int BLK_W        = $clog2(SEMA_COUNT + 1);

  localparam logic signed [VAL_W-1:0] SEMA_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] SEMA_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_SCHEDULE = 3'd1,
    CMD_SLEEP    = 3'd2,
    CMD_WAIT     = 3'd3,
    CMD_SIGNAL   = 3'd4,
    CMD_INIT     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [SEMA_ID_W-1:0]    sema_id;
    logic [VAL_W-1:0]        sleep_ms;
    logic signed [VAL_W-1:0] init_value;
  } in_req_t;

  typedef struct packed {
    logic [THREAD_W-1:0]     running_thread;
    logic                    caller_blocked;
    logic                    woken_valid;
    logic [THREAD_W-1:0]     woken_thread;
    logic                    none_ready;
    logic signed [VAL_W-1:0] sema_count;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_search;
    logic search_end;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/round_robin_thread_scheduler.sv]
// top level of the round robin thread scheduler with counting semaphores
// depends on rrts_pkg, rrts_ctrl and rrts_dp
//
//   channel | ports                          | payload
//   input   | in_valid, in_stall, in_data    | rrts_pkg::in_req_t (one command)
//   result  | out_valid, out_stall, out_data | rrts_pkg::out_rsp_t (one per command)
//
// one request at a time: accept, an execute state, then a ring search of one
// thread per cycle for schedule, sleep, a blocking wait or a waking signal,
// then a done state that loads the output register once it is free
// synchronous active-low reset clears all thread and semaphore state
// a stalled result holds in the output register while the next request runs
`default_nettype none

module round_robin_thread_scheduler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rrts_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rrts_pkg::out_rsp_t      out_data
);

  rrts_pkg::ctrl_cmd_t ctrl_cmd;
  rrts_pkg::dp_stat_t  dp_stat;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd),
    .in_stall (in_stall)
  );

  rrts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[rtl/rrts_ctrl.sv]
// sequencing state machine of the scheduler
// depends on rrts_pkg; drives rrts_dp through ctrl_cmd_t, reads dp_stat_t
`default_nettype none

module rrts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire rrts_pkg::dp_stat_t stat,
  output rrts_pkg::ctrl_cmd_t     cmd,
  output logic                    in_stall
);

  rrts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rrts_pkg::ST_EXEC;
      end
      rrts_pkg::ST_EXEC: begin
        state_nxt = stat.need_search ? rrts_pkg::ST_SEARCH : rrts_pkg::ST_DONE;
      end
      rrts_pkg::ST_SEARCH: begin
        if (stat.search_end) state_nxt = rrts_pkg::ST_DONE;
      end
      rrts_pkg::ST_DONE: begin
        if (!stat.out_busy) state_nxt = rrts_pkg::ST_IDLE;
      end
      default: state_nxt = rrts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      rrts_pkg::ST_EXEC:   cmd.exec = 1'b1;
      rrts_pkg::ST_SEARCH: cmd.step = 1'b1;
      rrts_pkg::ST_DONE:   cmd.finish = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/rrts_dp.sv]
// scheduler datapath: thread and semaphore state, ring search, result register
// depends on rrts_pkg; controlled by rrts_ctrl
`default_nettype none

module rrts_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rrts_pkg::in_req_t   in_data,
  input  wire rrts_pkg::ctrl_cmd_t cmd,
  output rrts_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rrts_pkg::out_rsp_t       out_data
);

  localparam int TIW = rrts_pkg::THREAD_IDX_W;
  localparam int VW  = rrts_pkg::VAL_W;
  localparam logic [TIW-1:0] LAST_T = TIW'(rrts_pkg::THREAD_COUNT - 1);

  rrts_pkg::in_req_t       req_r;
  logic [TIW-1:0]          cur_r, cur_nxt;
  logic [VW-1:0]           sleep_r [rrts_pkg::THREAD_COUNT];
  logic [VW-1:0]           sleep_nxt [rrts_pkg::THREAD_COUNT];
  logic [rrts_pkg::BLK_W-1:0] blk_on_r [rrts_pkg::THREAD_COUNT];
  logic [rrts_pkg::BLK_W-1:0] blk_on_nxt [rrts_pkg::THREAD_COUNT];
  logic signed [VW-1:0]    sema_r [rrts_pkg::SEMA_COUNT];
  logic signed [VW-1:0]    sema_nxt [rrts_pkg::SEMA_COUNT];
  logic [TIW-1:0]          probe_r, probe_nxt;
  logic [TIW-1:0]          cnt_r, cnt_nxt;
  logic                    blk_r, blk_nxt;
  logic                    wv_r, wv_nxt;
  logic [TIW-1:0]          wt_r, wt_nxt;
  logic                    nr_r, nr_nxt;
  rrts_pkg::out_rsp_t      out_r;
  logic                    out_valid_r;

  logic [rrts_pkg::SEMA_IDX_W-1:0] sid;
  logic                    sema_ok;
  logic [rrts_pkg::BLK_W-1:0] blk_code;
  logic signed [VW-1:0]    sema_cur, sema_dec, sema_inc;
  logic                    dec_neg, inc_le0;
  logic                    wake_mode;
  logic [TIW-1:0]          t_next;
  logic                    hit, last;

  assign sid      = rrts_pkg::SEMA_IDX_W'(req_r.sema_id);
  assign sema_ok  = 5'(req_r.sema_id) < 5'(rrts_pkg::SEMA_COUNT);
  assign blk_code = rrts_pkg::BLK_W'(req_r.sema_id) + rrts_pkg::BLK_W'(1);
  assign sema_cur = sema_r[sid];
  assign sema_dec = (sema_cur == rrts_pkg::SEMA_MIN) ? sema_cur : sema_cur - VW'(1);
  assign sema_inc = (sema_cur == rrts_pkg::SEMA_MAX) ? sema_cur : sema_cur + VW'(1);
  assign dec_neg  = sema_dec[VW-1];
  assign inc_le0  = sema_inc[VW-1] || (sema_inc == '0);
  assign wake_mode = (req_r.cmd == rrts_pkg::CMD_SIGNAL);

  // one ring position per search step
  assign t_next = (probe_r == LAST_T) ? '0 : probe_r + TIW'(1);
  assign hit = wake_mode ? (blk_on_r[t_next] == blk_code)
                         : (blk_on_r[t_next] == '0 && sleep_r[t_next] == '0);
  assign last = (cnt_r == LAST_T);

  always_comb begin
    stat.need_search = 1'b0;
    unique case (req_r.cmd)
      rrts_pkg::CMD_SCHEDULE,
      rrts_pkg::CMD_SLEEP:  stat.need_search = 1'b1;
      rrts_pkg::CMD_WAIT:   stat.need_search = sema_ok && dec_neg;
      rrts_pkg::CMD_SIGNAL: stat.need_search = sema_ok && inc_le0;
      default:              stat.need_search = 1'b0;
    endcase
    stat.search_end = hit || last;
    stat.out_busy   = out_valid_r && out_stall;
  end

  always_comb begin
    cur_nxt    = cur_r;
    sleep_nxt  = sleep_r;
    blk_on_nxt = blk_on_r;
    sema_nxt   = sema_r;
    probe_nxt  = probe_r;
    cnt_nxt    = cnt_r;
    blk_nxt    = blk_r;
    wv_nxt     = wv_r;
    wt_nxt     = wt_r;
    nr_nxt     = nr_r;
    if (cmd.exec) begin
      probe_nxt = cur_r;
      cnt_nxt   = '0;
      blk_nxt   = 1'b0;
      wv_nxt    = 1'b0;
      wt_nxt    = '0;
      nr_nxt    = 1'b0;
      unique case (req_r.cmd)
        rrts_pkg::CMD_TICK: begin
          for (int i = 0; i < rrts_pkg::THREAD_COUNT; i++) begin
            if (sleep_r[i] != '0) sleep_nxt[i] = sleep_r[i] - VW'(1);
          end
        end
        rrts_pkg::CMD_SLEEP: sleep_nxt[cur_r] = req_r.sleep_ms;
        rrts_pkg::CMD_WAIT: begin
          if (sema_ok) begin
            sema_nxt[sid] = sema_dec;
            if (dec_neg) begin
              blk_on_nxt[cur_r] = blk_code;
              blk_nxt = 1'b1;
            end
          end
        end
        rrts_pkg::CMD_SIGNAL: begin
          if (sema_ok) sema_nxt[sid] = sema_inc;
        end
        rrts_pkg::CMD_INIT: begin
          if (sema_ok) sema_nxt[sid] = req_r.init_value;
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      probe_nxt = t_next;
      cnt_nxt   = cnt_r + TIW'(1);
      if (hit) begin
        if (wake_mode) begin
          blk_on_nxt[t_next] = '0;
          wv_nxt = 1'b1;
          wt_nxt = t_next;
        end else begin
          cur_nxt = t_next;
        end
      end else if (last && !wake_mode) begin
        // nobody ready, current thread keeps running
        nr_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < rrts_pkg::THREAD_COUNT; i++) begin
        sleep_r[i]  <= '0;
        blk_on_r[i] <= '0;
      end
      for (int j = 0; j < rrts_pkg::SEMA_COUNT; j++) begin
        sema_r[j] <= '0;
      end
    end else begin
      cur_r    <= cur_nxt;
      cnt_r    <= cnt_nxt;
      sleep_r  <= sleep_nxt;
      blk_on_r <= blk_on_nxt;
      sema_r   <= sema_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    probe_r <= probe_nxt;
    blk_r   <= blk_nxt;
    wv_r    <= wv_nxt;
    wt_r    <= wt_nxt;
    nr_r    <= nr_nxt;
    if (cmd.finish) begin
      out_r.running_thread <= rrts_pkg::THREAD_W'(cur_r);
      out_r.caller_blocked <= blk_r;
      out_r.woken_valid    <= wv_r;
      out_r.woken_thread   <= rrts_pkg::THREAD_W'(wt_r);
      out_r.none_ready     <= nr_r;
      out_r.sema_count     <= sema_ok ? sema_cur : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cur_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= LAST_T)
    else $error("running thread outside the ring");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished request did not reach the output register");

  a_blk_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.caller_blocked && out_r.woken_valid))
    else $error("result reports both a block and a wakeup");

  a_nr_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.none_ready |-> !out_r.woken_valid)
    else $error("result reports no ready thread on a signal");

endmodule

`default_nettype wire

[verif/round_robin_thread_scheduler_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for round_robin_thread_scheduler: directed and random
// scheduler requests, with each result predicted and compared in order
// depends on rrts_pkg and the round_robin_thread_scheduler rtl

module round_robin_thread_scheduler_tb;

  localparam int MAX_IDLE         = 14;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 4 * (3 + rrts_pkg::THREAD_COUNT);
  localparam int REPORT_LIMIT     = 10;
  localparam int LONG_SLEEP_TICKS = 200;

  // codes outside cmd_t, expected to leave the state alone
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  class sched_scoreboard;
    bit [rrts_pkg::THREAD_W-1:0]     cur_thread;
    bit [rrts_pkg::VAL_W-1:0]        sleep_cnt [rrts_pkg::THREAD_COUNT];
    // 0 not waiting, else semaphore + 1
    bit [rrts_pkg::BLK_W-1:0]        waiting_on [rrts_pkg::THREAD_COUNT];
    bit signed [rrts_pkg::VAL_W-1:0] sema_val [rrts_pkg::SEMA_COUNT];
    rrts_pkg::out_rsp_t              pending_results [$];
    int commands, results, failures, blocks, wakeups, idle_reschedules;

    function bit [rrts_pkg::THREAD_W-1:0] ring_next(bit [rrts_pkg::THREAD_W-1:0] t);
      return (t == rrts_pkg::THREAD_COUNT - 1) ? '0 : t + 1'b1;
    endfunction

    // walks the ring from the next thread back to the current one;
    // returns 1 when nothing is ready and the current thread keeps running
    function bit move_to_ready();
      bit [rrts_pkg::THREAD_W-1:0] t;
      t = cur_thread;
      for (int n = 0; n < rrts_pkg::THREAD_COUNT; n++) begin
        t = ring_next(t);
        if (waiting_on[t] == 0 && sleep_cnt[t] == 0) begin
          cur_thread = t;
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function rrts_pkg::out_rsp_t apply_command(rrts_pkg::in_req_t req);
      rrts_pkg::out_rsp_t r;
      bit [rrts_pkg::THREAD_W-1:0] t;
      bit sema_ok;
      int unsigned sid;
      r = '0;
      sid = req.sema_id;
      sema_ok = (sid < rrts_pkg::SEMA_COUNT);
      case (req.cmd)
        rrts_pkg::CMD_TICK: begin
          foreach (sleep_cnt[i])
            if (sleep_cnt[i] != 0) sleep_cnt[i]--;
        end
        rrts_pkg::CMD_SCHEDULE: r.none_ready = move_to_ready();
        rrts_pkg::CMD_SLEEP: begin
          sleep_cnt[cur_thread] = req.sleep_ms;
          r.none_ready = move_to_ready();
        end
        rrts_pkg::CMD_WAIT: begin
          if (sema_ok) begin
            if (sema_val[sid] != rrts_pkg::SEMA_MIN) sema_val[sid]--;
            if (sema_val[sid] < 0) begin
              waiting_on[cur_thread] = rrts_pkg::BLK_W'(sid + 1);
              r.caller_blocked = 1'b1;
              r.none_ready = move_to_ready();
            end
          end
        end
        rrts_pkg::CMD_SIGNAL: begin
          if (sema_ok) begin
            if (sema_val[sid] != rrts_pkg::SEMA_MAX) sema_val[sid]++;
            if (sema_val[sid] <= 0) begin
              t = cur_thread;
              for (int n = 0; n < rrts_pkg::THREAD_COUNT && !r.woken_valid; n++) begin
                t = ring_next(t);
                if (waiting_on[t] == sid + 1) begin
                  waiting_on[t] = '0;
                  r.woken_valid = 1'b1;
                  r.woken_thread = t;
                end
              end
            end
          end
        end
        rrts_pkg::CMD_INIT: begin
          if (sema_ok) sema_val[sid] = req.init_value;
        end
        default: ;
      endcase
      r.running_thread = cur_thread;
      r.sema_count = sema_ok ? sema_val[sid] : '0;
      return r;
    endfunction

    function void note_request(rrts_pkg::in_req_t req);
      rrts_pkg::out_rsp_t r;
      r = apply_command(req);
      commands++;
      blocks += r.caller_blocked;
      wakeups += r.woken_valid;
      idle_reschedules += r.none_ready;
      pending_results.push_back(r);
    endfunction

    function void report_mismatch(string what, rrts_pkg::out_rsp_t want,
                                  rrts_pkg::out_rsp_t got);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: %s: expected thread=%0d blocked=%0b woken=%0b/%0d none=%0b cnt=%0d",
                 $time, what, want.running_thread, want.caller_blocked, want.woken_valid,
                 want.woken_thread, want.none_ready, want.sema_count,
                 "\n    got thread=%0d blocked=%0b woken=%0b/%0d none=%0b cnt=%0d",
                 got.running_thread, got.caller_blocked, got.woken_valid,
                 got.woken_thread, got.none_ready, got.sema_count);
    endfunction

    function void check_result(rrts_pkg::out_rsp_t got);
      rrts_pkg::out_rsp_t want;
      results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.running_thread !== want.running_thread ||
          got.caller_blocked !== want.caller_blocked ||
          got.woken_valid    !== want.woken_valid ||
          got.woken_thread   !== want.woken_thread ||
          got.none_ready     !== want.none_ready ||
          got.sema_count     !== want.sema_count)
        report_mismatch("result mismatch", want, got);
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rrts_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rrts_pkg::out_rsp_t out_data;

  sched_scoreboard sb = new();
  int max_in_gap = 0;
  int max_out_stall = 0;
  bit long_hold_req = 1'b0;

  round_robin_thread_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
    end
  end

  function automatic rrts_pkg::in_req_t make_cmd(logic [2:0] cmd, int sid, int slp,
                                                 int ival);
    rrts_pkg::in_req_t r;
    r.cmd = cmd;
    r.sema_id = rrts_pkg::SEMA_ID_W'(sid);
    r.sleep_ms = rrts_pkg::VAL_W'(slp);
    r.init_value = rrts_pkg::VAL_W'(ival);
    return r;
  endfunction

  // mostly small sleeps and counts near zero so threads block and wake often
  function automatic rrts_pkg::in_req_t random_command();
    rrts_pkg::in_req_t r;
    int unsigned pick;
    r = make_cmd(rrts_pkg::CMD_TICK, $urandom_range(0, 3), $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) r.cmd = rrts_pkg::CMD_TICK;
    else if (pick < 34) r.cmd = rrts_pkg::CMD_SCHEDULE;
    else if (pick < 48) begin
      r.cmd = rrts_pkg::CMD_SLEEP;
      r.sleep_ms = ($urandom_range(0, 9) == 0) ? rrts_pkg::VAL_W'($urandom_range(7, 40))
                                               : rrts_pkg::VAL_W'($urandom_range(0, 6));
    end
    else if (pick < 69) r.cmd = rrts_pkg::CMD_WAIT;
    else if (pick < 90) r.cmd = rrts_pkg::CMD_SIGNAL;
    else if (pick < 98) begin
      r.cmd = rrts_pkg::CMD_INIT;
      r.init_value = ($urandom_range(0, 9) == 0) ?
                     rrts_pkg::VAL_W'($urandom) :
                     rrts_pkg::VAL_W'(int'($urandom_range(0, 4)) - 2);
    end
    else r.cmd = (pick == 98) ? CMD_SPARE_6 : CMD_SPARE_7;
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(rrts_pkg::in_req_t req);
    int gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic run_random(int count, int in_gap, int out_hold);
    max_in_gap = in_gap;
    max_out_stall = out_hold;
    repeat (count) send_request(random_command());
  endtask

  initial begin : result_sink
    int hold;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        hold = $urandom_range(0, max_out_stall);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.outstanding());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rrts_pkg::in_req_t directed [$];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed.push_back(make_cmd(rrts_pkg::CMD_TICK, 0, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_SCHEDULE, 0, 0, 0));
    // saturation at both ends of the count
    directed.push_back(make_cmd(rrts_pkg::CMD_INIT, 0, 0, 32767));
    directed.push_back(make_cmd(rrts_pkg::CMD_SIGNAL, 0, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_INIT, 1, 0, -32768));
    directed.push_back(make_cmd(rrts_pkg::CMD_WAIT, 1, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_SIGNAL, 2, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_INIT, 3, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_WAIT, 3, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_SIGNAL, 3, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_SIGNAL, 1, 0, 0));
    // zero sleep is a plain yield
    directed.push_back(make_cmd(rrts_pkg::CMD_SLEEP, 0, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_SLEEP, 0, LONG_SLEEP_TICKS, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_SLEEP, 0, 3, 0));
    directed.push_back(make_cmd(CMD_SPARE_6, 1, 65535, -1));
    directed.push_back(make_cmd(CMD_SPARE_7, 2, 0, 0));
    // block every awake thread until no one is ready
    directed.push_back(make_cmd(rrts_pkg::CMD_INIT, 2, 0, -10));
    repeat (4) directed.push_back(make_cmd(rrts_pkg::CMD_WAIT, 2, 0, 0));
    // init leaves blocked threads alone, so a positive count wakes no one
    directed.push_back(make_cmd(rrts_pkg::CMD_INIT, 2, 0, 5));
    directed.push_back(make_cmd(rrts_pkg::CMD_SIGNAL, 2, 0, 0));
    repeat (3) directed.push_back(make_cmd(rrts_pkg::CMD_TICK, 0, 0, 0));
    directed.push_back(make_cmd(rrts_pkg::CMD_SCHEDULE, 0, 0, 0));

    max_in_gap = MAX_IDLE;
    max_out_stall = MAX_IDLE;
    foreach (directed[i]) send_request(directed[i]);

    // let the long sleep run out so every thread takes part below
    max_in_gap = 0;
    max_out_stall = 0;
    repeat (LONG_SLEEP_TICKS)
      send_request(make_cmd(rrts_pkg::CMD_TICK, $urandom_range(0, 3), $urandom, $urandom));

    run_random(400, MAX_IDLE, MAX_IDLE);
    run_random(300, 0, 0);
    // result side holds off while requests keep coming
    long_hold_req = 1'b1;
    run_random(100, 0, 0);
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    run_random(300, MAX_IDLE, 0);
    run_random(300, 0, MAX_IDLE);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests, checked %0d results, %0d mismatches",
             sb.commands, sb.results, sb.failures);
    $display("saw %0d blocking waits, %0d wakeups, %0d reschedules with no ready thread",
             sb.blocks, sb.wakeups, sb.idle_reschedules);
    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
